// ----- rtl/core/pepq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pepq_pkg
// shared types and constants of the entry pool queue manager
// ----------------------------------------------------------------------------
package pepq_pkg;

   localparam int MaxEntries = 32;
   localparam int NumQueues  = 8;
   localparam int EntryWidth = 5;
   localparam int IdxWidth   = 6;
   localparam int QueueWidth = 3;
   localparam int StepWidth  = 6;

   typedef logic [IdxWidth-1:0]   idx_type;
   typedef logic [EntryWidth-1:0] entry_type;
   typedef logic [QueueWidth-1:0] queue_type;

   localparam idx_type IDX_NONE = idx_type'(MaxEntries);

   typedef enum logic [3:0] {
      OP_ALLOC        = 4'd0,
      OP_FREE         = 4'd1,
      OP_CLEAR_QUEUE  = 4'd2,
      OP_QUEUE_EMPTY  = 4'd3,
      OP_ENQUEUE      = 4'd4,
      OP_PEEK         = 4'd5,
      OP_POP          = 4'd6,
      OP_REMOVE       = 4'd7,
      OP_NO_CHILDREN  = 4'd8,
      OP_ADD_CHILD    = 4'd9,
      OP_REMOVE_CHILD = 4'd10,
      OP_DETACH       = 4'd11
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_WALK,
      ST_READ,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic load;
      logic walk;
      logic read;
      logic write;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic is_walk;
      logic needs_cut;
      logic needs_write;
      logic tgt_ok;
      logic walk_hit;
      logic walk_end;
   } dp_stat_type;

endpackage
`default_nettype wire

// ----- rtl/core/pepq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pepq_ctrl
// sequencer: accepts a word, steps the datapath through its phases
// ----------------------------------------------------------------------------
module pepq_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output pepq_pkg::dp_cmd_type cmd,
   input  wire pepq_pkg::dp_stat_type stat
);

   pepq_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != pepq_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pepq_pkg::ST_IDLE: begin
            if (req_valid) state_in = pepq_pkg::ST_LOAD;
         end
         pepq_pkg::ST_LOAD: begin
            if (stat.is_walk) state_in = pepq_pkg::ST_WALK;
            else if (stat.needs_cut && stat.tgt_ok) state_in = pepq_pkg::ST_READ;
            else if (stat.needs_write) state_in = pepq_pkg::ST_WRITE;
            else state_in = pepq_pkg::ST_DONE;
         end
         pepq_pkg::ST_WALK: begin
            if (stat.walk_hit) state_in = pepq_pkg::ST_READ;
            else if (stat.walk_end) state_in = pepq_pkg::ST_DONE;
         end
         pepq_pkg::ST_READ:  state_in = pepq_pkg::ST_WRITE;
         pepq_pkg::ST_WRITE: state_in = pepq_pkg::ST_DONE;
         pepq_pkg::ST_DONE: begin
            if (out_free) state_in = pepq_pkg::ST_IDLE;
         end
         default: state_in = pepq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         pepq_pkg::ST_IDLE:  cmd.accept = req_valid;
         pepq_pkg::ST_LOAD:  cmd.load = 1'b1;
         pepq_pkg::ST_WALK:  cmd.walk = 1'b1;
         pepq_pkg::ST_READ:  cmd.read = 1'b1;
         pepq_pkg::ST_WRITE: cmd.write = 1'b1;
         pepq_pkg::ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pepq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/pepq_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pepq_datapath
// link tables, list heads, walk pointer and result registers
// ----------------------------------------------------------------------------
module pepq_datapath (
   input  wire                    clock,
   input  wire                    reset,
   input  wire pepq_pkg::dp_cmd_type cmd,
   output pepq_pkg::dp_stat_type  stat,
   input  wire [3:0]              req_operation,
   input  wire [4:0]              req_entry,
   input  wire [2:0]              req_queue_id,
   input  wire [4:0]              req_parent_entry,
   output logic                   rsp_found,
   output logic [4:0]             rsp_result_entry,
   output logic                   rsp_is_empty
);

   localparam int N = pepq_pkg::MaxEntries;
   localparam int Q = pepq_pkg::NumQueues;

   pepq_pkg::idx_type link_fwd_ff   [N];
   pepq_pkg::idx_type link_back_ff  [N];
   pepq_pkg::idx_type parent_ff     [N];
   pepq_pkg::idx_type child_first_ff[N];
   pepq_pkg::idx_type child_last_ff [N];
   pepq_pkg::idx_type sib_fwd_ff    [N];
   pepq_pkg::idx_type sib_back_ff   [N];
   pepq_pkg::idx_type q_first_ff    [Q];
   pepq_pkg::idx_type q_last_ff     [Q];
   pepq_pkg::idx_type free_top_ff, free_bot_ff;

   logic [3:0]          op_ff;
   pepq_pkg::entry_type e_ff, p_ff;
   pepq_pkg::queue_type q_ff;

   pepq_pkg::idx_type tgt_ff, tgt_in, par_ff, pv_ff, nx_ff, cur_ff;
   logic [pepq_pkg::StepWidth-1:0] steps_ff;
   logic found_ff, found_in, empty_ff, empty_in;
   pepq_pkg::entry_type res_ff;
   logic out_found_ff, out_empty_ff;
   pepq_pkg::entry_type out_res_ff;

   pepq_pkg::entry_type t5, h5, last5;
   pepq_pkg::idx_type   ap_last;

   assign t5 = tgt_ff[pepq_pkg::EntryWidth-1:0];
   assign h5 = (op_ff == pepq_pkg::OP_DETACH) ? par_ff[pepq_pkg::EntryWidth-1:0] : e_ff;

   // load phase decode and walk hit/end status
   always_comb begin
      tgt_in         = {1'b0, e_ff};
      stat.is_walk   = 1'b0;
      stat.needs_cut = 1'b0;
      stat.needs_write = 1'b0;
      found_in       = 1'b0;
      empty_in       = 1'b0;
      case (op_ff)
         pepq_pkg::OP_ALLOC: begin
            tgt_in = free_top_ff;
            stat.needs_cut = 1'b1;
         end
         pepq_pkg::OP_FREE, pepq_pkg::OP_CLEAR_QUEUE,
         pepq_pkg::OP_ENQUEUE, pepq_pkg::OP_ADD_CHILD: stat.needs_write = 1'b1;
         pepq_pkg::OP_QUEUE_EMPTY: empty_in = q_first_ff[q_ff][pepq_pkg::EntryWidth];
         pepq_pkg::OP_PEEK: tgt_in = q_first_ff[q_ff];
         pepq_pkg::OP_POP: begin
            tgt_in = q_first_ff[q_ff];
            stat.needs_cut = 1'b1;
         end
         pepq_pkg::OP_REMOVE: stat.is_walk = 1'b1;
         pepq_pkg::OP_NO_CHILDREN: empty_in = child_first_ff[e_ff][pepq_pkg::EntryWidth];
         pepq_pkg::OP_REMOVE_CHILD: begin
            tgt_in = child_first_ff[e_ff];
            stat.needs_cut = 1'b1;
         end
         pepq_pkg::OP_DETACH: begin
            tgt_in = parent_ff[e_ff][pepq_pkg::EntryWidth] ? pepq_pkg::IDX_NONE
                                                            : {1'b0, e_ff};
            stat.needs_cut = 1'b1;
         end
         default: tgt_in = pepq_pkg::IDX_NONE;
      endcase
      stat.tgt_ok = !tgt_in[pepq_pkg::EntryWidth];
      if ((op_ff == pepq_pkg::OP_PEEK) || stat.needs_cut) found_in = stat.tgt_ok;
      stat.walk_hit = !cur_ff[pepq_pkg::EntryWidth] &&
                      (cur_ff[pepq_pkg::EntryWidth-1:0] == e_ff) &&
                      (steps_ff != pepq_pkg::StepWidth'(N));
      stat.walk_end = cur_ff[pepq_pkg::EntryWidth] ||
                      (steps_ff == pepq_pkg::StepWidth'(N));
   end

   assign ap_last = (op_ff == pepq_pkg::OP_ADD_CHILD) ? child_last_ff[p_ff] : q_last_ff[q_ff];
   assign last5   = ap_last[pepq_pkg::EntryWidth-1:0];

   // request, walk, read and result registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_operation;
         e_ff     <= req_entry;
         q_ff     <= req_queue_id;
         p_ff     <= req_parent_entry;
         found_ff <= 1'b0;
         empty_ff <= 1'b0;
         res_ff   <= '0;
      end
      if (cmd.load) begin
         tgt_ff   <= tgt_in;
         par_ff   <= parent_ff[e_ff];
         found_ff <= found_in;
         empty_ff <= empty_in;
         res_ff   <= found_in ? tgt_in[pepq_pkg::EntryWidth-1:0] : '0;
         cur_ff   <= q_first_ff[q_ff];
         steps_ff <= '0;
      end
      if (cmd.walk) begin
         if (stat.walk_hit) begin
            tgt_ff   <= {1'b0, e_ff};
            found_ff <= 1'b1;
            res_ff   <= e_ff;
         end else begin
            cur_ff   <= link_fwd_ff[cur_ff[pepq_pkg::EntryWidth-1:0]];
            steps_ff <= steps_ff + 1'b1;
         end
      end
      if (cmd.read) begin
         if ((op_ff == pepq_pkg::OP_REMOVE_CHILD) || (op_ff == pepq_pkg::OP_DETACH)) begin
            pv_ff <= sib_back_ff[t5];
            nx_ff <= sib_fwd_ff[t5];
         end else begin
            pv_ff <= link_back_ff[t5];
            nx_ff <= link_fwd_ff[t5];
         end
      end
      if (cmd.out_load) begin
         out_found_ff <= found_ff;
         out_res_ff   <= res_ff;
         out_empty_ff <= empty_ff;
      end
   end

   // link tables
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            link_fwd_ff[i]    <= (i == 0) ? pepq_pkg::IDX_NONE : pepq_pkg::idx_type'(i - 1);
            link_back_ff[i]   <= pepq_pkg::idx_type'(i + 1);
            parent_ff[i]      <= pepq_pkg::IDX_NONE;
            child_first_ff[i] <= pepq_pkg::IDX_NONE;
            child_last_ff[i]  <= pepq_pkg::IDX_NONE;
            sib_fwd_ff[i]     <= pepq_pkg::IDX_NONE;
            sib_back_ff[i]    <= pepq_pkg::IDX_NONE;
         end
         for (int j = 0; j < Q; j++) begin
            q_first_ff[j] <= pepq_pkg::IDX_NONE;
            q_last_ff[j]  <= pepq_pkg::IDX_NONE;
         end
         free_top_ff <= pepq_pkg::idx_type'(N - 1);
         free_bot_ff <= '0;
      end else if (cmd.write) begin
         case (op_ff)
            pepq_pkg::OP_ALLOC: begin
               if (!pv_ff[pepq_pkg::EntryWidth]) link_fwd_ff[pv_ff[4:0]] <= nx_ff;
               else free_top_ff <= nx_ff;
               if (!nx_ff[pepq_pkg::EntryWidth]) link_back_ff[nx_ff[4:0]] <= pv_ff;
               else free_bot_ff <= pv_ff;
               link_fwd_ff[t5]    <= pepq_pkg::IDX_NONE;
               link_back_ff[t5]   <= pepq_pkg::IDX_NONE;
               parent_ff[t5]      <= pepq_pkg::IDX_NONE;
               child_first_ff[t5] <= pepq_pkg::IDX_NONE;
               child_last_ff[t5]  <= pepq_pkg::IDX_NONE;
               sib_fwd_ff[t5]     <= pepq_pkg::IDX_NONE;
               sib_back_ff[t5]    <= pepq_pkg::IDX_NONE;
            end
            pepq_pkg::OP_FREE: begin
               link_fwd_ff[e_ff]  <= free_top_ff;
               link_back_ff[e_ff] <= pepq_pkg::IDX_NONE;
               if (!free_top_ff[pepq_pkg::EntryWidth])
                  link_back_ff[free_top_ff[4:0]] <= {1'b0, e_ff};
               else free_bot_ff <= {1'b0, e_ff};
               free_top_ff <= {1'b0, e_ff};
            end
            pepq_pkg::OP_CLEAR_QUEUE: begin
               q_first_ff[q_ff] <= pepq_pkg::IDX_NONE;
               q_last_ff[q_ff]  <= pepq_pkg::IDX_NONE;
            end
            pepq_pkg::OP_ENQUEUE: begin
               link_back_ff[e_ff] <= ap_last;
               link_fwd_ff[e_ff]  <= pepq_pkg::IDX_NONE;
               if (!ap_last[pepq_pkg::EntryWidth]) link_fwd_ff[last5] <= {1'b0, e_ff};
               else q_first_ff[q_ff] <= {1'b0, e_ff};
               q_last_ff[q_ff] <= {1'b0, e_ff};
            end
            pepq_pkg::OP_POP, pepq_pkg::OP_REMOVE: begin
               if (!pv_ff[pepq_pkg::EntryWidth]) link_fwd_ff[pv_ff[4:0]] <= nx_ff;
               else q_first_ff[q_ff] <= nx_ff;
               if (!nx_ff[pepq_pkg::EntryWidth]) link_back_ff[nx_ff[4:0]] <= pv_ff;
               else q_last_ff[q_ff] <= pv_ff;
               link_fwd_ff[t5]  <= pepq_pkg::IDX_NONE;
               link_back_ff[t5] <= pepq_pkg::IDX_NONE;
            end
            pepq_pkg::OP_ADD_CHILD: begin
               parent_ff[e_ff]   <= {1'b0, p_ff};
               sib_back_ff[e_ff] <= ap_last;
               sib_fwd_ff[e_ff]  <= pepq_pkg::IDX_NONE;
               if (!ap_last[pepq_pkg::EntryWidth]) sib_fwd_ff[last5] <= {1'b0, e_ff};
               else child_first_ff[p_ff] <= {1'b0, e_ff};
               child_last_ff[p_ff] <= {1'b0, e_ff};
            end
            pepq_pkg::OP_REMOVE_CHILD, pepq_pkg::OP_DETACH: begin
               if (!pv_ff[pepq_pkg::EntryWidth]) sib_fwd_ff[pv_ff[4:0]] <= nx_ff;
               else child_first_ff[h5] <= nx_ff;
               if (!nx_ff[pepq_pkg::EntryWidth]) sib_back_ff[nx_ff[4:0]] <= pv_ff;
               else child_last_ff[h5] <= pv_ff;
               sib_fwd_ff[t5]  <= pepq_pkg::IDX_NONE;
               sib_back_ff[t5] <= pepq_pkg::IDX_NONE;
               parent_ff[t5]   <= pepq_pkg::IDX_NONE;
            end
            default: free_top_ff <= free_top_ff;
         endcase
      end
   end

   assign rsp_found        = out_found_ff;
   assign rsp_result_entry = out_res_ff;
   assign rsp_is_empty     = out_empty_ff;

endmodule
`default_nettype wire

// ----- rtl/core/process_entry_pool_queue_manager.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// process_entry_pool_queue_manager
// pool of 32 linked entries: free stack, 8 fifo queues and a parent/child tree
//
// request channel (req_*): one operation word with entry, queue and parent
// fields, taken when req_valid is high and req_stall is low.
// response channel (rsp_*): exactly one word per request with found,
// result_entry and is_empty, held while rsp_stall is high.
// one request is worked on at a time by a sequencer stepping the link tables:
// tests, peek and unknown codes go from load to the response register; free,
// clear, enqueue and add child write their links first; alloc, pop, remove
// first child and detach read and then write them (neither when there is
// nothing to take); remove given walks its queue one link per cycle, then
// reads and writes if it finds the entry. the next request is taken once its
// result is in the response register, even while that word is stalled.
// reset is synchronous: all lists return to their initial form (every entry
// on the free stack, highest on top) in the reset cycle itself.
// ----------------------------------------------------------------------------
module process_entry_pool_queue_manager (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire [3:0]  req_operation,
   input  wire [4:0]  req_entry,
   input  wire [2:0]  req_queue_id,
   input  wire [4:0]  req_parent_entry,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic       rsp_found,
   output logic [4:0] rsp_result_entry,
   output logic       rsp_is_empty
);

   pepq_pkg::dp_cmd_type  cmd;
   pepq_pkg::dp_stat_type stat;

   pepq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   pepq_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_operation    (req_operation),
      .req_entry        (req_entry),
      .req_queue_id     (req_queue_id),
      .req_parent_entry (req_parent_entry),
      .rsp_found        (rsp_found),
      .rsp_result_entry (rsp_result_entry),
      .rsp_is_empty     (rsp_is_empty)
   );

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the entry pool queue manager against a behavioral copy of its free
// stack, fifo queues and parent/child tree, under random gaps and stalls
// ----------------------------------------------------------------------------
module tb;

   typedef struct packed {
      logic [3:0] op;
      logic [4:0] entry;
      logic [2:0] qid;
      logic [4:0] parent;
   } req_word_type;

   typedef struct packed {
      logic       found;
      logic [4:0] res;
      logic       empty;
   } rsp_word_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [3:0] req_operation;
   logic [4:0] req_entry;
   logic [2:0] req_queue_id;
   logic [4:0] req_parent_entry;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_found;
   logic [4:0] rsp_result_entry;
   logic       rsp_is_empty;

   process_entry_pool_queue_manager DUT (.*);

   // pool model
   int m_fwd[pepq_pkg::MaxEntries];
   int m_back[pepq_pkg::MaxEntries];
   int m_free_top, m_free_bot;
   int m_qfirst[pepq_pkg::NumQueues];
   int m_qlast[pepq_pkg::NumQueues];
   int m_parent[pepq_pkg::MaxEntries];
   int m_cfirst[pepq_pkg::MaxEntries];
   int m_clast[pepq_pkg::MaxEntries];
   int m_sfwd[pepq_pkg::MaxEntries];
   int m_sback[pepq_pkg::MaxEntries];

   req_word_type pending_words[$];
   rsp_word_type expected_rsp[$];
   int  mismatch_count;
   int  req_gap;
   int  rsp_gap;
   bit  hold_off;
   bit  stim_done;

   function automatic bit valid_idx(int v);
      return v >= 0 && v < pepq_pkg::MaxEntries;
   endfunction

   task automatic pool_reset();
      for (int i = 0; i < pepq_pkg::MaxEntries; i++) begin
         m_fwd[i] = (i == 0) ? pepq_pkg::MaxEntries : i - 1;
         m_back[i] = (i + 1 < pepq_pkg::MaxEntries) ? i + 1 : pepq_pkg::MaxEntries;
         m_parent[i] = pepq_pkg::MaxEntries;
         m_cfirst[i] = pepq_pkg::MaxEntries;
         m_clast[i] = pepq_pkg::MaxEntries;
         m_sfwd[i] = pepq_pkg::MaxEntries;
         m_sback[i] = pepq_pkg::MaxEntries;
      end
      for (int i = 0; i < pepq_pkg::NumQueues; i++) begin
         m_qfirst[i] = pepq_pkg::MaxEntries;
         m_qlast[i] = pepq_pkg::MaxEntries;
      end
      m_free_top = pepq_pkg::MaxEntries - 1;
      m_free_bot = 0;
   endtask

   task automatic link_unlink(ref int fwd[pepq_pkg::MaxEntries],
                              ref int back[pepq_pkg::MaxEntries],
                              ref int first, ref int last, input int e);
      int p, n;
      p = back[e];
      n = fwd[e];
      if (valid_idx(p)) fwd[p] = n; else first = n;
      if (valid_idx(n)) back[n] = p; else last = p;
      fwd[e] = pepq_pkg::MaxEntries;
      back[e] = pepq_pkg::MaxEntries;
   endtask

   task automatic link_append(ref int fwd[pepq_pkg::MaxEntries],
                              ref int back[pepq_pkg::MaxEntries],
                              ref int first, ref int last, input int e);
      int p;
      p = last;
      back[e] = p;
      fwd[e] = pepq_pkg::MaxEntries;
      if (valid_idx(p)) fwd[p] = e; else first = e;
      last = e;
   endtask

   task automatic pool_apply(input req_word_type w, output rsp_word_type r);
      int e, q, t, cur, p;
      bit found, empty;
      found = 0;
      empty = 0;
      t = 0;
      e = w.entry;
      q = w.qid;
      case (pepq_pkg::op_type'(w.op))
         pepq_pkg::OP_ALLOC: begin
            t = m_free_top;
            if (valid_idx(t)) begin
               link_unlink(m_fwd, m_back, m_free_top, m_free_bot, t);
               m_parent[t] = pepq_pkg::MaxEntries;
               m_cfirst[t] = pepq_pkg::MaxEntries;
               m_clast[t] = pepq_pkg::MaxEntries;
               m_sfwd[t] = pepq_pkg::MaxEntries;
               m_sback[t] = pepq_pkg::MaxEntries;
               found = 1;
            end
         end
         pepq_pkg::OP_FREE: begin
            t = m_free_top;
            m_fwd[e] = t;
            m_back[e] = pepq_pkg::MaxEntries;
            if (valid_idx(t)) m_back[t] = e; else m_free_bot = e;
            m_free_top = e;
         end
         pepq_pkg::OP_CLEAR_QUEUE: begin
            m_qfirst[q] = pepq_pkg::MaxEntries;
            m_qlast[q] = pepq_pkg::MaxEntries;
         end
         pepq_pkg::OP_QUEUE_EMPTY: empty = !valid_idx(m_qfirst[q]);
         pepq_pkg::OP_ENQUEUE: link_append(m_fwd, m_back, m_qfirst[q], m_qlast[q], e);
         pepq_pkg::OP_PEEK: if (valid_idx(m_qfirst[q])) begin
            found = 1;
            t = m_qfirst[q];
         end
         pepq_pkg::OP_POP: if (valid_idx(m_qfirst[q])) begin
            t = m_qfirst[q];
            link_unlink(m_fwd, m_back, m_qfirst[q], m_qlast[q], t);
            found = 1;
         end
         pepq_pkg::OP_REMOVE: begin
            cur = m_qfirst[q];
            for (int s = 0; s < pepq_pkg::MaxEntries && valid_idx(cur) && !found; s++) begin
               if (cur == e) begin
                  link_unlink(m_fwd, m_back, m_qfirst[q], m_qlast[q], e);
                  found = 1;
                  t = e;
               end else begin
                  cur = m_fwd[cur];
               end
            end
         end
         pepq_pkg::OP_NO_CHILDREN: empty = !valid_idx(m_cfirst[e]);
         pepq_pkg::OP_ADD_CHILD: begin
            p = w.parent;
            m_parent[e] = p;
            link_append(m_sfwd, m_sback, m_cfirst[p], m_clast[p], e);
         end
         pepq_pkg::OP_REMOVE_CHILD: if (valid_idx(m_cfirst[e])) begin
            t = m_cfirst[e];
            link_unlink(m_sfwd, m_sback, m_cfirst[e], m_clast[e], t);
            m_parent[t] = pepq_pkg::MaxEntries;
            found = 1;
         end
         pepq_pkg::OP_DETACH: if (valid_idx(m_parent[e])) begin
            p = m_parent[e];
            link_unlink(m_sfwd, m_sback, m_cfirst[p], m_clast[p], e);
            m_parent[e] = pepq_pkg::MaxEntries;
            found = 1;
            t = e;
         end
         default: ;
      endcase
      r.found = found;
      r.res = found ? t[4:0] : 5'd0;
      r.empty = empty;
   endtask

   function automatic int pick_gap();
      int k;
      k = $urandom_range(0, 99);
      if (k < 45) return 0;
      if (k < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic req_word_type make_word(pepq_pkg::op_type op, int e, int q, int p);
      req_word_type w;
      w.op = op;
      w.entry = e[4:0];
      w.qid = q[2:0];
      w.parent = p[4:0];
      return w;
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         req_gap <= 0;
      end else if (req_valid && !req_stall) begin
         req_word_type w;
         rsp_word_type r;
         w = {req_operation, req_entry, req_queue_id, req_parent_entry};
         pool_apply(w, r);
         expected_rsp.push_back(r);
         req_valid <= 0;
         req_gap <= pick_gap();
      end else if (!req_valid) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
         end else if (pending_words.size() > 0 && !hold_off) begin
            req_word_type w;
            w = pending_words.pop_front();
            req_valid <= 1;
            req_operation <= w.op;
            req_entry <= w.entry;
            req_queue_id <= w.qid;
            req_parent_entry <= w.parent;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
         rsp_gap <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_word_type e;
            if (expected_rsp.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("unexpected word: found=%0d entry=%0d empty=%0d",
                           rsp_found, rsp_result_entry, rsp_is_empty);
            end else begin
               e = expected_rsp.pop_front();
               if (e.found !== rsp_found || e.res !== rsp_result_entry
                   || e.empty !== rsp_is_empty) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10)
                     $display("mismatch: exp found=%0d entry=%0d empty=%0d, got %0d %0d %0d",
                              e.found, e.res, e.empty,
                              rsp_found, rsp_result_entry, rsp_is_empty);
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_stall <= 1;
         end else if ($urandom_range(0, 5) == 0) begin
            rsp_gap <= pick_gap();
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   initial begin
      int op, q;
      mismatch_count = 0;
      hold_off = 0;
      stim_done = 0;
      reset = 1;
      req_valid = 0;
      req_operation = 0;
      req_entry = 0;
      req_queue_id = 0;
      req_parent_entry = 0;
      rsp_stall = 0;
      pool_reset();
      repeat (10) @(posedge clock);
      reset <= 0;

      // directed
      pending_words.push_back(make_word(pepq_pkg::OP_QUEUE_EMPTY, 0, 7, 0));
      pending_words.push_back(make_word(pepq_pkg::OP_PEEK, 0, 0, 0));
      pending_words.push_back(make_word(pepq_pkg::OP_POP, 0, 7, 0));
      pending_words.push_back(make_word(pepq_pkg::OP_ALLOC, 0, 0, 0));
      pending_words.push_back(make_word(pepq_pkg::OP_ALLOC, 0, 0, 0));
      pending_words.push_back(make_word(pepq_pkg::OP_ENQUEUE, 31, 7, 0));
      pending_words.push_back(make_word(pepq_pkg::OP_ENQUEUE, 30, 7, 0));
      pending_words.push_back(make_word(pepq_pkg::OP_PEEK, 0, 7, 0));
      pending_words.push_back(make_word(pepq_pkg::OP_REMOVE, 30, 7, 0));
      pending_words.push_back(make_word(pepq_pkg::OP_REMOVE, 5, 7, 0));
      pending_words.push_back(make_word(pepq_pkg::OP_POP, 0, 7, 0));
      pending_words.push_back(make_word(pepq_pkg::OP_QUEUE_EMPTY, 0, 7, 0));
      pending_words.push_back(make_word(pepq_pkg::OP_ADD_CHILD, 30, 31, 31));
      pending_words.push_back(make_word(pepq_pkg::OP_ADD_CHILD, 0, 31, 31));
      pending_words.push_back(make_word(pepq_pkg::OP_NO_CHILDREN, 31, 0, 0));
      pending_words.push_back(make_word(pepq_pkg::OP_DETACH, 0, 0, 0));
      pending_words.push_back(make_word(pepq_pkg::OP_REMOVE_CHILD, 31, 0, 0));
      pending_words.push_back(make_word(pepq_pkg::OP_REMOVE_CHILD, 31, 0, 0));
      pending_words.push_back(make_word(pepq_pkg::OP_NO_CHILDREN, 31, 0, 0));
      pending_words.push_back(make_word(pepq_pkg::OP_FREE, 31, 0, 0));
      pending_words.push_back(make_word(pepq_pkg::OP_CLEAR_QUEUE, 0, 7, 0));
      pending_words.push_back(make_word(pepq_pkg::op_type'(4'd12), 31, 7, 31));
      pending_words.push_back(make_word(pepq_pkg::op_type'(4'd15), 0, 0, 0));
      while (pending_words.size() > 0 || req_valid) @(negedge clock);

      // pause the sender until every expected word has come back
      hold_off = 1;
      while (expected_rsp.size() > 0) @(negedge clock);
      hold_off = 0;

      // random, weighted toward queue and tree traffic
      for (int i = 0; i < 530; i++) begin
         op = $urandom_range(0, 99);
         q = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 2);
         if (op < 10) op = pepq_pkg::OP_ALLOC;
         else if (op < 16) op = pepq_pkg::OP_FREE;
         else if (op < 19) op = pepq_pkg::OP_CLEAR_QUEUE;
         else if (op < 25) op = pepq_pkg::OP_QUEUE_EMPTY;
         else if (op < 42) op = pepq_pkg::OP_ENQUEUE;
         else if (op < 48) op = pepq_pkg::OP_PEEK;
         else if (op < 58) op = pepq_pkg::OP_POP;
         else if (op < 68) op = pepq_pkg::OP_REMOVE;
         else if (op < 73) op = pepq_pkg::OP_NO_CHILDREN;
         else if (op < 85) op = pepq_pkg::OP_ADD_CHILD;
         else if (op < 91) op = pepq_pkg::OP_REMOVE_CHILD;
         else if (op < 97) op = pepq_pkg::OP_DETACH;
         else op = $urandom_range(12, 15);
         pending_words.push_back(make_word(pepq_pkg::op_type'(op[3:0]),
                                           $urandom_range(0, 31), q,
                                           $urandom_range(0, 31)));
      end
      while (pending_words.size() > 0 || req_valid || expected_rsp.size() > 0)
         @(negedge clock);
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/pepq_pkg.sv
rtl/core/pepq_ctrl.sv
rtl/core/pepq_datapath.sv
rtl/core/process_entry_pool_queue_manager.sv
test/tb.sv
